FILE: hdl/dlct_pkg.sv
// Shared widths, register indexes, reset values and types for the dark line center tracker.
`default_nettype none
package dlct_pkg;

    localparam int COORD_BITS = 10;
    localparam int HALF_BITS  = COORD_BITS - 1;
    localparam int RED_BITS   = 8;
    localparam int IDX_BITS   = 3;
    localparam int DATA_BITS  = (COORD_BITS > RED_BITS) ? COORD_BITS : RED_BITS;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [HALF_BITS-1:0]  half_t;
    typedef logic [RED_BITS-1:0]   red_t;
    typedef logic [COORD_BITS:0]   coord_ext_t;

    localparam logic [IDX_BITS-1:0] REG_SEARCH_ROW    = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_DARK_THRESH   = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_WINDOW_HALF   = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_DEFAULT_LEFT  = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_DEFAULT_RIGHT = 3'd4;

    localparam coord_t RST_SEARCH_ROW    = coord_t'(470);
    localparam red_t   RST_DARK_THRESH   = red_t'(40);
    localparam half_t  RST_WINDOW_HALF   = half_t'(100);
    localparam coord_t RST_DEFAULT_LEFT  = coord_t'(100);
    localparam coord_t RST_DEFAULT_RIGHT = coord_t'(540);
    localparam coord_t RST_CENTER        = coord_t'(320);

    localparam coord_ext_t EDGE_MARGIN = coord_ext_t'(2);

    typedef struct packed {
        logic left_hit;
        logic right_hit;
    } window_hit_t;

endpackage
`default_nettype wire

FILE: hdl/dark_line_center_tracker_unit.sv
// Top level of the dark line center tracker: input stage, edge state, result register.
//
//  channel   ports                                           direction
//  pixel     s_valid s_ready s_pixel_col s_pixel_row         in
//            s_red_level s_frame_end
//  center    m_valid m_ready m_line_center                   out
//  config    cfg_wr_en cfg_index cfg_wdata                   in
//
// One pixel a cycle unless a frame-end pixel waits: a pixel sits in the input register,
// then its edge test and, on a frame end, the center update run into the result register.
// A result is registered as its frame-end pixel leaves the input register.
// Reset sets the registers and the tracked center to their defaults and clears the flags.
// A frame-end pixel waits on a full result register; pixels behind it wait with it.
`default_nettype none
module dark_line_center_tracker_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire dlct_pkg::coord_t                s_pixel_col,
    input  wire dlct_pkg::coord_t                s_pixel_row,
    input  wire dlct_pkg::red_t                  s_red_level,
    input  wire logic                            s_frame_end,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output dlct_pkg::coord_t                     m_line_center,
    input  wire logic                            cfg_wr_en,
    input  wire logic [dlct_pkg::IDX_BITS-1:0]   cfg_index,
    input  wire logic [dlct_pkg::DATA_BITS-1:0]  cfg_wdata
);

    dlct_pkg::coord_t search_row_reg;
    dlct_pkg::red_t   dark_thresh_reg;
    dlct_pkg::half_t  window_half_reg;
    dlct_pkg::coord_t default_left_reg;
    dlct_pkg::coord_t default_right_reg;

    logic             in_valid_reg;
    dlct_pkg::coord_t in_col_reg;
    dlct_pkg::coord_t in_row_reg;
    dlct_pkg::red_t   in_red_reg;
    logic             in_end_reg;

    dlct_pkg::coord_t center_reg,  center_next;
    dlct_pkg::coord_t left_reg,    left_next;
    dlct_pkg::coord_t right_reg,   right_next;
    logic             left_found_reg,  left_found_next;
    logic             right_found_reg, right_found_next;

    logic             out_valid_reg;
    dlct_pkg::coord_t out_center_reg;

    logic                  out_free;
    logic                  advance;
    logic                  end_fire;
    logic                  dark;
    dlct_pkg::window_hit_t hit;
    dlct_pkg::coord_t      left_sel;
    dlct_pkg::coord_t      right_sel;
    dlct_pkg::coord_ext_t  edge_sum;
    dlct_pkg::coord_ext_t  mid_sum;
    dlct_pkg::coord_t      new_center;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            search_row_reg    <= dlct_pkg::RST_SEARCH_ROW;
            dark_thresh_reg   <= dlct_pkg::RST_DARK_THRESH;
            window_half_reg   <= dlct_pkg::RST_WINDOW_HALF;
            default_left_reg  <= dlct_pkg::RST_DEFAULT_LEFT;
            default_right_reg <= dlct_pkg::RST_DEFAULT_RIGHT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dlct_pkg::REG_SEARCH_ROW:
                    search_row_reg <= cfg_wdata[dlct_pkg::COORD_BITS-1:0];
                dlct_pkg::REG_DARK_THRESH:
                    dark_thresh_reg <= cfg_wdata[dlct_pkg::RED_BITS-1:0];
                dlct_pkg::REG_WINDOW_HALF:
                    window_half_reg <= cfg_wdata[dlct_pkg::HALF_BITS-1:0];
                dlct_pkg::REG_DEFAULT_LEFT:
                    default_left_reg <= cfg_wdata[dlct_pkg::COORD_BITS-1:0];
                dlct_pkg::REG_DEFAULT_RIGHT:
                    default_right_reg <= cfg_wdata[dlct_pkg::COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: a frame-end pixel holds until the result register is free.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_end_reg || out_free);
    assign end_fire = advance && in_end_reg;
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_col_reg <= s_pixel_col;
            in_row_reg <= s_pixel_row;
            in_red_reg <= s_red_level;
            in_end_reg <= s_frame_end;
        end
    end

    assign dark = (in_row_reg == search_row_reg) && (in_red_reg < dark_thresh_reg);

    dlct_window_check u_window (
        .col         (in_col_reg),
        .center      (center_reg),
        .window_half (window_half_reg),
        .dark        (dark),
        .hit         (hit)
    );

    always_comb begin
        left_next        = left_reg;
        right_next       = right_reg;
        left_found_next  = left_found_reg;
        right_found_next = right_found_reg;
        center_next      = center_reg;

        if (hit.left_hit && !left_found_reg) begin
            left_next       = in_col_reg;
            left_found_next = 1'b1;
        end
        if (hit.right_hit) begin
            right_next       = in_col_reg;
            right_found_next = 1'b1;
        end

        // The frame-end pixel counts before the center is formed.
        left_sel   = left_found_next  ? left_next  : default_left_reg;
        right_sel  = right_found_next ? right_next : default_right_reg;
        edge_sum   = dlct_pkg::coord_ext_t'(left_sel) + dlct_pkg::coord_ext_t'(right_sel);
        mid_sum    = dlct_pkg::coord_ext_t'(edge_sum[dlct_pkg::COORD_BITS:1])
                     + dlct_pkg::coord_ext_t'(center_reg);
        new_center = mid_sum[dlct_pkg::COORD_BITS:1];

        if (in_end_reg) begin
            center_next      = new_center;
            left_found_next  = 1'b0;
            right_found_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg      <= dlct_pkg::RST_CENTER;
            left_found_reg  <= 1'b0;
            right_found_reg <= 1'b0;
            left_reg        <= '0;
            right_reg       <= '0;
        end else if (advance) begin
            center_reg      <= center_next;
            left_found_reg  <= left_found_next;
            right_found_reg <= right_found_next;
            left_reg        <= left_next;
            right_reg       <= right_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= end_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (end_fire) begin
            out_center_reg <= new_center;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_line_center = out_center_reg;

`ifndef NO_ASSERTIONS
    a_flags_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        end_fire |=> !left_found_reg && !right_found_reg)
        else $error("found flags not cleared after frame end");

    a_center_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !end_fire |=> $stable(center_reg))
        else $error("tracked center moved without a frame end");

    a_result_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        end_fire |=> m_valid && (m_line_center == center_reg))
        else $error("result register differs from new tracked center");

    a_left_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        left_found_reg && !end_fire |=> $stable(left_reg))
        else $error("left edge overwritten after it was found");
`endif

endmodule
`default_nettype wire

FILE: hdl/dlct_window_check.sv
// Window and parity test of one column against the tracked center.
`default_nettype none
module dlct_window_check (
    input  wire dlct_pkg::coord_t      col,
    input  wire dlct_pkg::coord_t      center,
    input  wire dlct_pkg::half_t       window_half,
    input  wire logic                  dark,
    output dlct_pkg::window_hit_t      hit
);

    dlct_pkg::coord_ext_t col_x;
    dlct_pkg::coord_ext_t ctr_x;
    dlct_pkg::coord_ext_t w_x;
    logic                 even;
    logic                 ge_neg_w;
    logic                 le_w_m2;
    logic                 ge_neg_w_p2;
    logic                 le_w;

    // Offsets compared as sums so that nothing goes negative.
    assign col_x = dlct_pkg::coord_ext_t'(col);
    assign ctr_x = dlct_pkg::coord_ext_t'(center);
    assign w_x   = dlct_pkg::coord_ext_t'(window_half);
    assign even  = (col[0] == center[0]);

    assign ge_neg_w    = (col_x + w_x) >= ctr_x;
    assign le_w_m2     = (col_x + dlct_pkg::EDGE_MARGIN) <= (ctr_x + w_x);
    assign ge_neg_w_p2 = (col_x + w_x) >= (ctr_x + dlct_pkg::EDGE_MARGIN);
    assign le_w        = col_x <= (ctr_x + w_x);

    always_comb begin
        hit.left_hit  = dark && even && ge_neg_w && le_w_m2;
        hit.right_hit = dark && even && ge_neg_w_p2 && le_w;
    end

endmodule
`default_nettype wire

FILE: tb/tb_dark_line_center_tracker_unit.sv
// Self-checking testbench for the dark line center tracker: random pixel frames, scoreboard.
`default_nettype none
module tb_dark_line_center_tracker_unit;

    localparam int COORD_MAX       = (1 << dlct_pkg::COORD_BITS) - 1;
    localparam int NUM_PHASES      = 9;
    localparam int HOLD_PHASE      = 3;
    localparam int PHASE_ITEMS     = 200;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 5000;

    typedef logic [dlct_pkg::IDX_BITS-1:0]  cfg_idx_t;
    typedef logic [dlct_pkg::DATA_BITS-1:0] cfg_data_t;

    typedef struct packed {
        dlct_pkg::coord_t col;
        dlct_pkg::coord_t row;
        dlct_pkg::red_t   red;
        logic             last;
    } pixel_t;

    typedef struct packed {
        dlct_pkg::coord_t search_row;
        dlct_pkg::red_t   thresh;
        dlct_pkg::half_t  window;
        dlct_pkg::coord_t dflt_left;
        dlct_pkg::coord_t dflt_right;
        dlct_pkg::coord_t center;
        dlct_pkg::coord_t left_edge;
        logic             left_found;
        dlct_pkg::coord_t right_edge;
        logic             right_found;
    } tracker_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_ALTERNATE
    } ready_mode_e;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    dlct_pkg::coord_t s_pixel_col = '0;
    dlct_pkg::coord_t s_pixel_row = '0;
    dlct_pkg::red_t   s_red_level = '0;
    logic             s_frame_end = 1'b0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    dlct_pkg::coord_t m_line_center;
    logic             cfg_wr_en = 1'b0;
    cfg_idx_t         cfg_index = '0;
    cfg_data_t        cfg_wdata = '0;

    dark_line_center_tracker_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_col   (s_pixel_col),
        .s_pixel_row   (s_pixel_row),
        .s_red_level   (s_red_level),
        .s_frame_end   (s_frame_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_line_center (m_line_center),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // sent_trk follows the pixels as they are queued, seen_trk as they are transferred
    tracker_t         sent_trk;
    tracker_t         seen_trk;
    pixel_t           pending_pixels[$];
    dlct_pkg::coord_t expected_centers[$];
    int               pushed_count   = 0;
    int               accepted_count = 0;
    int               errors         = 0;
    logic             hold_req       = 1'b0;

    function automatic tracker_t tracker_at_reset();
        tracker_t t;
        t.search_row  = dlct_pkg::RST_SEARCH_ROW;
        t.thresh      = dlct_pkg::RST_DARK_THRESH;
        t.window      = dlct_pkg::RST_WINDOW_HALF;
        t.dflt_left   = dlct_pkg::RST_DEFAULT_LEFT;
        t.dflt_right  = dlct_pkg::RST_DEFAULT_RIGHT;
        t.center      = dlct_pkg::RST_CENTER;
        t.left_edge   = '0;
        t.left_found  = 1'b0;
        t.right_edge  = '0;
        t.right_found = 1'b0;
        return t;
    endfunction

    function automatic void apply_reg(inout tracker_t t, input cfg_idx_t idx,
                                      input cfg_data_t data);
        case (idx)
            dlct_pkg::REG_SEARCH_ROW:    t.search_row = data[dlct_pkg::COORD_BITS-1:0];
            dlct_pkg::REG_DARK_THRESH:   t.thresh     = data[dlct_pkg::RED_BITS-1:0];
            dlct_pkg::REG_WINDOW_HALF:   t.window     = data[dlct_pkg::HALF_BITS-1:0];
            dlct_pkg::REG_DEFAULT_LEFT:  t.dflt_left  = data[dlct_pkg::COORD_BITS-1:0];
            dlct_pkg::REG_DEFAULT_RIGHT: t.dflt_right = data[dlct_pkg::COORD_BITS-1:0];
            default: ;
        endcase
    endfunction

    // Update the edge search with one pixel; on a frame end return 1 and the new center.
    function automatic logic track_pixel(inout tracker_t t, input pixel_t p,
                                         output dlct_pkg::coord_t center);
        int                   off;
        int                   w;
        dlct_pkg::coord_t     l_edge;
        dlct_pkg::coord_t     r_edge;
        dlct_pkg::coord_ext_t sum;
        off    = int'(p.col) - int'(t.center);
        w      = int'(t.window);
        center = t.center;
        if (p.row == t.search_row && p.red < t.thresh && !off[0]) begin
            if (!t.left_found && off >= -w && off <= w - 2) begin
                t.left_edge  = p.col;
                t.left_found = 1'b1;
            end
            if (off >= 2 - w && off <= w) begin
                t.right_edge  = p.col;
                t.right_found = 1'b1;
            end
        end
        if (!p.last)
            return 1'b0;
        l_edge = t.left_found ? t.left_edge : t.dflt_left;
        r_edge = t.right_found ? t.right_edge : t.dflt_right;
        sum = dlct_pkg::coord_ext_t'(l_edge) + dlct_pkg::coord_ext_t'(r_edge);
        sum = dlct_pkg::coord_ext_t'(sum[dlct_pkg::COORD_BITS:1])
              + dlct_pkg::coord_ext_t'(t.center);
        center        = sum[dlct_pkg::COORD_BITS:1];
        t.center      = center;
        t.left_found  = 1'b0;
        t.right_found = 1'b0;
        return 1'b1;
    endfunction

    // Queue one pixel; columns off the image are dropped, since such pixels never arrive.
    function automatic void push_pixel(int col, int row, int red, logic last);
        pixel_t           px;
        dlct_pkg::coord_t unused_center;
        if (col < 0 || col > COORD_MAX)
            return;
        px.col  = dlct_pkg::coord_t'(col);
        px.row  = dlct_pkg::coord_t'(row);
        px.red  = dlct_pkg::red_t'(red);
        px.last = last;
        void'(track_pixel(sent_trk, px, unused_center));
        pending_pixels.push_back(px);
        pushed_count++;
    endfunction

    function automatic int pick_red();
        int thr;
        thr = int'(sent_trk.thresh);
        if ($urandom_range(9, 0) < 6 && thr != 0)
            return $urandom_range(thr - 1, 0);
        return $urandom_range(255, thr);
    endfunction

    function automatic void push_frame_end();
        if ($urandom_range(1, 0))
            push_pixel($urandom_range(COORD_MAX, 0), int'(sent_trk.search_row), pick_red(),
                       1'b1);
        else
            push_pixel($urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0),
                       $urandom_range(255, 0), 1'b1);
    endfunction

    function automatic void gen_frame(int max_len);
        int kind;
        int n;
        int c;
        int w;
        int row;
        int col;
        int step_max;
        int dir;
        int lim[7];
        kind = $urandom_range(9, 0);
        c    = int'(sent_trk.center);
        w    = int'(sent_trk.window);
        row  = int'(sent_trk.search_row);
        n    = $urandom_range(max_len, 1);
        case (kind)
            6: begin
                // hit the window limits of both edge searches exactly
                lim = '{-w - 2, -w, -w + 1, 2 - w, w - 2, w, w + 2};
                foreach (lim[k])
                    if ($urandom_range(1, 0))
                        push_pixel(c + lim[k], row, pick_red(), 1'b0);
            end
            7: ;
            9: begin
                for (int k = 0; k < n; k++)
                    push_pixel($urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0),
                               $urandom_range(255, 0), 1'b0);
            end
            default: begin
                // sweep the window, descending for out-of-order frames
                dir      = (kind == 8) ? -1 : 1;
                step_max = (2 * w + 8) / n + 1;
                col      = c - dir * (w + $urandom_range(4, 0));
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(7, 0) == 0)
                        push_pixel(col,
                                   $urandom_range(1, 0) ? row + 1 : $urandom_range(COORD_MAX, 0),
                                   pick_red(), 1'b0);
                    else
                        push_pixel(col, row, pick_red(), 1'b0);
                    col += dir * $urandom_range(step_max, 1);
                end
            end
        endcase
        push_frame_end();
    endfunction

    task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        apply_reg(sent_trk, idx, data);
        apply_reg(seen_trk, idx, data);
    endtask

    // Upper data bits beyond a register's width are random and must be dropped.
    task automatic set_config(int row, int thr, int w, int dl, int dr);
        cfg_data_t data;
        write_reg(dlct_pkg::REG_SEARCH_ROW, cfg_data_t'(row));
        data = cfg_data_t'($urandom);
        data[dlct_pkg::RED_BITS-1:0] = dlct_pkg::red_t'(thr);
        write_reg(dlct_pkg::REG_DARK_THRESH, data);
        write_reg(cfg_idx_t'(dlct_pkg::REG_DEFAULT_RIGHT + 1 + $urandom_range(2, 0)),
                  cfg_data_t'($urandom));
        data = cfg_data_t'($urandom);
        data[dlct_pkg::HALF_BITS-1:0] = dlct_pkg::half_t'(w);
        write_reg(dlct_pkg::REG_WINDOW_HALF, data);
        write_reg(dlct_pkg::REG_DEFAULT_LEFT, cfg_data_t'(dl));
        write_reg(dlct_pkg::REG_DEFAULT_RIGHT, cfg_data_t'(dr));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (accepted_count != pushed_count || expected_centers.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Pixel sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;
    always @(posedge aclk) begin
        pixel_t px;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                px = pending_pixels.pop_front();
                s_valid     <= 1'b1;
                s_pixel_col <= px.col;
                s_pixel_row <= px.row;
                s_red_level <= px.red;
                s_frame_end <= px.last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left   <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: stall pattern changes every so often, plus one long hold-off.
    ready_mode_e ready_mode = READY_ALWAYS;
    int          mode_left  = 0;
    int          hold_left  = 0;
    logic        hold_done  = 1'b0;
    logic [7:0]  ready_tick = '0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            ready_tick <= ready_tick + 1'b1;
            if (mode_left == 0) begin
                ready_mode <= ready_mode_e'($urandom_range(3, 0));
                mode_left  <= $urandom_range(150, 20);
            end else begin
                mode_left <= mode_left - 1;
            end
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                case (ready_mode)
                    READY_ALWAYS:    m_ready <= 1'b1;
                    READY_COIN:      m_ready <= 1'($urandom_range(1, 0));
                    READY_SPARSE:    m_ready <= ($urandom_range(4, 0) == 0);
                    READY_ALTERNATE: m_ready <= ready_tick[1];
                    default:         m_ready <= 1'b1;
                endcase
            end
        end
    end

    // Predict on each pixel transfer, check on each result transfer.
    always @(posedge aclk) begin
        pixel_t           px;
        dlct_pkg::coord_t center;
        dlct_pkg::coord_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                px = '{col: s_pixel_col, row: s_pixel_row, red: s_red_level, last: s_frame_end};
                if (track_pixel(seen_trk, px, center))
                    expected_centers.push_back(center);
                accepted_count++;
            end
            if (m_valid && m_ready) begin
                if (expected_centers.size() == 0) begin
                    $error("unexpected result: line_center %0d", m_line_center);
                    errors++;
                end else begin
                    want = expected_centers.pop_front();
                    if (m_line_center !== want) begin
                        $error("line_center mismatch: expected %0d, actual %0d", want,
                               m_line_center);
                        errors++;
                    end
                end
            end
        end
    end

    int stall_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles, %0d results outstanding",
                   stall_cycles, expected_centers.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int target;
        sent_trk = tracker_at_reset();
        seen_trk = tracker_at_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed frames on the reset settings: center 320, window 100, row 470, threshold 40.
        push_pixel(0, 0, 0, 1'b0);
        push_pixel(COORD_MAX, COORD_MAX, 255, 1'b0);
        push_pixel(218, 470, 0, 1'b0);   // just outside the left limit
        push_pixel(220, 470, 39, 1'b0);  // left limit, counts for the left edge only
        push_pixel(221, 470, 0, 1'b0);   // odd offset
        push_pixel(224, 470, 0, 1'b0);
        push_pixel(300, 470, 40, 1'b0);  // at threshold: not dark
        push_pixel(420, 470, 0, 1'b0);   // right limit
        push_pixel(422, 470, 0, 1'b0);
        push_pixel(COORD_MAX, COORD_MAX, 255, 1'b1);
        push_pixel(640, 469, 0, 1'b1);   // nothing found: both defaults
        push_pixel(418, 470, 0, 1'b1);   // frame-end pixel is itself the only edge
        push_pixel(269, 470, 0, 1'b0);
        push_pixel(271, 470, 10, 1'b0);
        push_pixel(469, 470, 0, 1'b0);
        push_pixel(0, 470, 0, 1'b1);
        push_pixel(449, 470, 0, 1'b0);   // out of order: left keeps first, right takes last
        push_pixel(289, 470, 0, 1'b0);
        push_pixel(5, 470, 255, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: set_config(0, 255, 2, 0, COORD_MAX);
                1: set_config(COORD_MAX, 0, 510, COORD_MAX, 0);
                2: set_config($urandom_range(COORD_MAX, 0), 128, 511,
                              $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0));
                3: set_config($urandom_range(COORD_MAX, 0), $urandom_range(255, 1),
                              $urandom_range(200, 2), $urandom_range(COORD_MAX, 0),
                              $urandom_range(COORD_MAX, 0));
                4: set_config($urandom_range(COORD_MAX, 0), 200, 1,
                              $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0));
                5: set_config($urandom_range(COORD_MAX, 0), 200, 0,
                              $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0));
                default: set_config($urandom_range(COORD_MAX, 0), $urandom_range(255, 1),
                                    $urandom_range(300, 2), $urandom_range(COORD_MAX, 0),
                                    $urandom_range(COORD_MAX, 0));
            endcase
            // short frames here so frame ends pile up behind the held-off receiver
            if (p == HOLD_PHASE)
                hold_req <= 1'b1;
            target = pushed_count + PHASE_ITEMS;
            while (pushed_count < target)
                gen_frame((p == HOLD_PHASE) ? 3 : 24);
        end
        wait_idle();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
hdl/dlct_pkg.sv
hdl/dlct_window_check.sv
hdl/dark_line_center_tracker_unit.sv
tb/tb_dark_line_center_tracker_unit.sv
